### hw/rtl/prfos_pkg.sv
// ----------------------------------------------------------------------------
// prfos_pkg
// Shared types and constants for the pulse rate block: parameter defaults,
// register indexes, reset values and the serial divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package prfos_pkg;

  localparam int INTERVAL_SLOTS_DEFAULT = 8;
  localparam int AVERAGE_WEIGHT_DEFAULT = 8;
  localparam int SAMPLE_BITS_DEFAULT    = 10;

  localparam int RATE_NUMERATOR = 60000;
  localparam int AVERAGE_RESET  = 512;

  localparam int INTERVAL_BITS  = 16;
  localparam int TIME_BITS      = 32;
  localparam int RATE_BITS      = 8;
  localparam int OFFSET_BITS    = 10;

  // serial divider: 32-bit dividend, 16-bit divisor and quotient
  localparam int DIV_DVD_BITS   = 32;
  localparam int DIV_Q_BITS     = 16;
  localparam int DIV_CNT_BITS   = $clog2(DIV_Q_BITS);

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THRESHOLD_OFFSET = 3'd0,
    REG_MIN_INTERVAL     = 3'd1,
    REG_MAX_INTERVAL     = 3'd2,
    REG_MIN_RATE         = 3'd3,
    REG_MAX_RATE         = 3'd4
  } cfg_reg_t;

  localparam logic [OFFSET_BITS-1:0]   THRESHOLD_OFFSET_RESET = 10'd10;
  localparam logic [INTERVAL_BITS-1:0] MIN_INTERVAL_RESET     = 16'd330;
  localparam logic [INTERVAL_BITS-1:0] MAX_INTERVAL_RESET     = 16'd1500;
  localparam logic [RATE_BITS-1:0]     MIN_RATE_RESET         = 8'd40;
  localparam logic [RATE_BITS-1:0]     MAX_RATE_RESET         = 8'd180;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/prfos_div.sv
// ----------------------------------------------------------------------------
// prfos_div
// Restoring divider, one quotient bit per cycle, 16 steps. The dividend's
// upper half must be below the divisor so the quotient fits 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module prfos_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [prfos_pkg::DIV_DVD_BITS-1:0]   dividend,
  input  logic [prfos_pkg::DIV_Q_BITS-1:0]     divisor,
  output logic [prfos_pkg::DIV_Q_BITS-1:0]     quotient,
  output prfos_pkg::div_stat_t                 stat
);
  import prfos_pkg::*;

  logic [DIV_Q_BITS-1:0]   rem;
  logic [DIV_Q_BITS-1:0]   low;
  logic [DIV_Q_BITS-1:0]   dsr;
  logic [DIV_Q_BITS-1:0]   quot;
  logic [DIV_CNT_BITS-1:0] count;
  logic                    busy;
  logic                    done;
  logic [DIV_Q_BITS:0]     trial;
  logic [DIV_Q_BITS:0]     diff;
  logic                    ge;

  assign trial = {rem, low[DIV_Q_BITS-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_BITS'(DIV_Q_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend[DIV_DVD_BITS-1:DIV_Q_BITS];
      low  <= dividend[DIV_Q_BITS-1:0];
      dsr  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[DIV_Q_BITS-1:0] : trial[DIV_Q_BITS-1:0];
      low  <= {low[DIV_Q_BITS-2:0], 1'b0};
      quot <= {quot[DIV_Q_BITS-2:0], ge};
    end
  end

  assign quotient  = quot;
  assign stat.busy = busy;
  assign stat.done = done;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && count == DIV_CNT_BITS'(DIV_Q_BITS - 1)) |=> (done && !busy))
    else $error("divider did not finish after last step");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");

endmodule

`default_nettype wire

### hw/rtl/prfos_ring.sv
// ----------------------------------------------------------------------------
// prfos_ring
// Interval ring in a synchronous memory with a running sum. A push reads the
// entry it replaces, then writes the new interval and corrects the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module prfos_ring #(
  parameter  int INTERVAL_SLOTS = prfos_pkg::INTERVAL_SLOTS_DEFAULT,
  localparam int SLOT_BITS      = $clog2(INTERVAL_SLOTS),
  localparam int SUM_BITS       = prfos_pkg::INTERVAL_BITS + $clog2(INTERVAL_SLOTS)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic [SLOT_BITS-1:0]                 slot,
  input  logic [prfos_pkg::INTERVAL_BITS-1:0]  value,
  input  logic                                 old_valid,
  output logic [SUM_BITS-1:0]                  sum,
  output logic                                 done
);
  import prfos_pkg::*;

  logic [INTERVAL_BITS-1:0] mem [INTERVAL_SLOTS];
  logic [INTERVAL_BITS-1:0] rd_data;
  logic [SLOT_BITS-1:0]     slot_q;
  logic [INTERVAL_BITS-1:0] value_q;
  logic                     old_valid_q;
  logic                     pend;

  always_ff @(posedge clk) begin
    if (push) begin
      rd_data <= mem[slot];
    end
    if (pend) begin
      mem[slot_q] <= value_q;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_q      <= slot;
      value_q     <= value;
      old_valid_q <= old_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
      sum  <= '0;
    end else begin
      pend <= push;
      done <= pend;
      if (pend) begin
        sum <= sum - (old_valid_q ? SUM_BITS'(rd_data) : SUM_BITS'(0)) + SUM_BITS'(value_q);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pulse_rate_from_optical_samples_top.sv
// ----------------------------------------------------------------------------
// pulse_rate_from_optical_samples_top
// Beat detection on optical samples with an averaged beats-per-minute result.
// ----------------------------------------------------------------------------
// Items are taken one at a time, as s_tready is high only in the idle state.
// A store adds the ring read-modify-write, the mean state and the 16-step
// serial rate divide. A stalled result holds off the next item until taken.
// Reset: synchronous; registers return to their defaults, ring contents stay
// undefined and are only summed once every slot holds an interval.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_rate_from_optical_samples_top #(
  parameter  int INTERVAL_SLOTS = prfos_pkg::INTERVAL_SLOTS_DEFAULT,
  parameter  int AVERAGE_WEIGHT = prfos_pkg::AVERAGE_WEIGHT_DEFAULT,
  parameter  int SAMPLE_BITS    = prfos_pkg::SAMPLE_BITS_DEFAULT,
  localparam int IN_BITS        = SAMPLE_BITS + prfos_pkg::TIME_BITS,
  localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // s_tdata: sample, timestamp_ms, zero pad
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [IN_TDATA_BITS-1:0]              s_tdata,
  // m_tdata: rate_bpm
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [prfos_pkg::RATE_BITS-1:0]       m_tdata,
  input  logic                                  cfg_we,
  input  logic [prfos_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [prfos_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import prfos_pkg::*;

  localparam int AVG_BITS  = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
  localparam int SLOT_BITS = $clog2(INTERVAL_SLOTS);
  localparam int CNT_BITS  = $clog2(INTERVAL_SLOTS + 1);
  localparam int SUM_BITS  = INTERVAL_BITS + $clog2(INTERVAL_SLOTS);

  // division by the constant weights through an exact reciprocal
  localparam int     AVG_W_BITS     = $clog2(AVERAGE_WEIGHT);
  localparam int     AVG_NUM_BITS   = AVG_BITS + AVG_W_BITS;
  localparam int     AVG_SHIFT      = AVG_NUM_BITS + AVG_W_BITS;
  localparam int     AVG_PROD_BITS  = 2 * AVG_NUM_BITS + 1;
  localparam longint AVG_RECIP      = ((longint'(1) << AVG_SHIFT) +
                                       longint'(AVERAGE_WEIGHT) - longint'(1)) /
                                      longint'(AVERAGE_WEIGHT);
  localparam int     MEAN_SHIFT     = SUM_BITS + SLOT_BITS;
  localparam int     MEAN_PROD_BITS = 2 * SUM_BITS + 1;
  localparam longint MEAN_RECIP     = ((longint'(1) << MEAN_SHIFT) +
                                       longint'(INTERVAL_SLOTS) - longint'(1)) /
                                      longint'(INTERVAL_SLOTS);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_AVG    = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_RING   = 7'b0001000,
    ST_MEAN   = 7'b0010000,
    ST_RATE   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state;

  logic [OFFSET_BITS-1:0]   threshold_offset;
  logic [INTERVAL_BITS-1:0] min_interval_ms;
  logic [INTERVAL_BITS-1:0] max_interval_ms;
  logic [RATE_BITS-1:0]     min_rate;
  logic [RATE_BITS-1:0]     max_rate;

  logic [AVG_BITS-1:0]      level_average;
  logic                     above_threshold;
  logic [TIME_BITS-1:0]     previous_beat_time;
  logic                     awaiting_first_beat;
  logic [SLOT_BITS-1:0]     ring_write_slot;
  logic [CNT_BITS-1:0]      stored_interval_count;

  logic [SAMPLE_BITS-1:0]   sample_q;
  logic [TIME_BITS-1:0]     time_q;
  logic [AVG_NUM_BITS-1:0]  avg_num;
  logic [AVG_PROD_BITS-1:0] avg_prod;
  logic [MEAN_PROD_BITS-1:0] mean_prod;
  logic [DIV_Q_BITS-1:0]    mean_q;
  logic                     force_zero;
  logic [DIV_Q_BITS-1:0]    rate_q;
  logic                     rate_zero;

  logic                     div_start;
  logic [DIV_DVD_BITS-1:0]  div_dividend;
  logic [DIV_Q_BITS-1:0]    div_divisor;
  logic [DIV_Q_BITS-1:0]    div_quotient;
  div_stat_t                div_stat;

  logic                     ring_push;
  logic [SUM_BITS-1:0]      ring_sum;
  logic                     ring_done;

  logic                     full;
  logic [AVG_BITS:0]        threshold;
  logic                     over;
  logic                     beat;
  logic [TIME_BITS-1:0]     interval;
  logic                     out_of_bounds;
  logic                     rate_ok;
  logic [RATE_BITS-1:0]     out_value;
  logic                     out_load;

  assign s_tready = (state == ST_IDLE);
  assign full     = (stored_interval_count == CNT_BITS'(INTERVAL_SLOTS));

  assign threshold     = {1'b0, level_average} + (AVG_BITS + 1)'(threshold_offset);
  assign over          = (AVG_BITS + 1)'(sample_q) > threshold;
  assign beat          = over && !above_threshold;
  assign interval      = time_q - previous_beat_time;
  assign out_of_bounds = (interval > TIME_BITS'(max_interval_ms)) ||
                         (interval < TIME_BITS'(min_interval_ms));
  assign ring_push     = (state == ST_DECIDE) && beat && !awaiting_first_beat &&
                         !out_of_bounds;

  assign avg_prod  = AVG_PROD_BITS'(avg_num) * AVG_PROD_BITS'(AVG_RECIP);
  assign mean_prod = MEAN_PROD_BITS'(ring_sum) * MEAN_PROD_BITS'(MEAN_RECIP);

  assign rate_ok   = !rate_zero && (rate_q >= DIV_Q_BITS'(min_rate)) &&
                     (rate_q <= DIV_Q_BITS'(max_rate));
  assign out_value = (!force_zero && full && rate_ok) ? rate_q[RATE_BITS-1:0] : '0;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  assign div_start    = (state == ST_MEAN);
  assign div_dividend = DIV_DVD_BITS'(RATE_NUMERATOR);
  assign div_divisor  = mean_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_offset <= THRESHOLD_OFFSET_RESET;
      min_interval_ms  <= MIN_INTERVAL_RESET;
      max_interval_ms  <= MAX_INTERVAL_RESET;
      min_rate         <= MIN_RATE_RESET;
      max_rate         <= MAX_RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD_OFFSET: threshold_offset <= cfg_data[OFFSET_BITS-1:0];
        REG_MIN_INTERVAL:     min_interval_ms  <= cfg_data[INTERVAL_BITS-1:0];
        REG_MAX_INTERVAL:     max_interval_ms  <= cfg_data[INTERVAL_BITS-1:0];
        REG_MIN_RATE:         min_rate         <= cfg_data[RATE_BITS-1:0];
        REG_MAX_RATE:         max_rate         <= cfg_data[RATE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= ST_IDLE;
      level_average         <= AVG_BITS'(AVERAGE_RESET);
      above_threshold       <= 1'b0;
      previous_beat_time    <= '0;
      awaiting_first_beat   <= 1'b1;
      ring_write_slot       <= '0;
      stored_interval_count <= '0;
      m_tvalid              <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_AVG;
          end
        end
        ST_AVG: begin
          level_average <= avg_prod[AVG_SHIFT +: AVG_BITS];
          state         <= ST_DECIDE;
        end
        ST_DECIDE: begin
          state <= ST_DONE;
          if (beat) begin
            above_threshold    <= 1'b1;
            previous_beat_time <= time_q;
            if (awaiting_first_beat) begin
              awaiting_first_beat <= 1'b0;
            end else if (!out_of_bounds) begin
              ring_write_slot <= (ring_write_slot == SLOT_BITS'(INTERVAL_SLOTS - 1)) ?
                                 '0 : ring_write_slot + 1'b1;
              if (!full) begin
                stored_interval_count <= stored_interval_count + 1'b1;
              end
              state <= ST_RING;
            end
          end else if (!over) begin
            above_threshold <= 1'b0;
          end
        end
        ST_RING: begin
          if (ring_done) begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          state <= ST_RATE;
        end
        ST_RATE: begin
          if (div_stat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      sample_q <= s_tdata[SAMPLE_BITS-1:0];
      time_q   <= s_tdata[SAMPLE_BITS +: TIME_BITS];
      avg_num  <= AVG_NUM_BITS'(level_average) * AVG_NUM_BITS'(AVERAGE_WEIGHT - 1) +
                  AVG_NUM_BITS'(s_tdata[SAMPLE_BITS-1:0]);
    end
    if (state == ST_DECIDE) begin
      force_zero <= beat && (awaiting_first_beat || out_of_bounds);
    end
    if (state == ST_RING && ring_done) begin
      mean_q <= mean_prod[MEAN_SHIFT +: DIV_Q_BITS];
    end
    if (state == ST_MEAN) begin
      rate_zero <= (mean_q == '0);
    end
    if (state == ST_RATE && div_stat.done) begin
      rate_q <= div_quotient;
    end
    if (out_load) begin
      m_tdata <= out_value;
    end
  end

  prfos_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  prfos_ring #(
    .INTERVAL_SLOTS (INTERVAL_SLOTS)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .push      (ring_push),
    .slot      (ring_write_slot),
    .value     (interval[INTERVAL_BITS-1:0]),
    .old_valid (full),
    .sum       (ring_sum),
    .done      (ring_done)
  );

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    stored_interval_count <= CNT_BITS'(INTERVAL_SLOTS))
    else $error("interval count beyond ring size");
  a_ring_turn: assert property (@(posedge clk) disable iff (rst)
    ring_push |-> ##2 (ring_done && state == ST_RING))
    else $error("ring update did not complete");
  a_rate_limits: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_value != '0) |-> (full && out_value >= min_rate && out_value <= max_rate))
    else $error("reported rate outside limits");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!s_tready && state == ST_AVG))
    else $error("accepted beat did not start the average");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - pulse rate from optical samples
// Streams samples with millisecond timestamps into the block and checks every
// rate beat against an in-bench predictor of the averaging, beat detection,
// interval ring and rate limits. A short table of hand-checked samples comes
// first, then boundary register settings, then randomised pulse trains with
// noise, missed beats and wild intervals under varying settings. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prfos_pkg::*;

  localparam int unsigned SLOTS          = 8;
  localparam int unsigned AVG_WEIGHT     = 8;
  localparam int unsigned SMP_BITS       = 10;
  localparam int unsigned TDATA_BITS     = ((SMP_BITS + 32 + 7) / 8) * 8;
  localparam int unsigned BPM_NUMERATOR  = 60000;
  localparam int unsigned AVG_START      = 512;
  localparam int unsigned OFFSET_START   = 10;
  localparam int unsigned GAP_MIN_START  = 330;
  localparam int unsigned GAP_MAX_START  = 1500;
  localparam int unsigned BPM_MIN_START  = 40;
  localparam int unsigned BPM_MAX_START  = 180;
  localparam logic [2:0]  CFG_FIRST_SPARE = 3'd5;
  localparam int unsigned TABLE_ROWS     = 25;
  localparam int unsigned RANDOM_SAMPLES = 880;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [31:0] TABLE_T0       = 32'hFFFF_EC78;  // wraps 5 s in

  typedef struct {
    logic [SMP_BITS-1:0] smp;
    logic [31:0]         ts;
    bit                  fixed;
    logic [7:0]          bpm;
  } probe_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_BITS-1:0] s_tdata = '0;   // sample, timestamp_ms, zero pad
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [RATE_BITS-1:0]  m_tdata;        // rate_bpm
  logic                  cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  pulse_rate_from_optical_samples_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state and register copies
  int unsigned avg_level    = AVG_START;
  bit          above        = 1'b0;
  bit          beat_seen    = 1'b0;
  int unsigned last_beat_ms = 0;
  logic [15:0] gap_ring [SLOTS];
  int unsigned ring_slot    = 0;
  int unsigned ring_fill    = 0;
  int unsigned thr_offset   = OFFSET_START;
  int unsigned gap_min      = GAP_MIN_START;
  int unsigned gap_max      = GAP_MAX_START;
  int unsigned bpm_min      = BPM_MIN_START;
  int unsigned bpm_max      = BPM_MAX_START;

  logic [7:0]  rate_queue [$];
  probe_t      probe_table [$];
  int unsigned samples_sent   = 0;
  int unsigned rates_checked  = 0;
  int unsigned rates_nonzero  = 0;
  int unsigned settings_used  = 1;
  int unsigned fail_count     = 0;
  int unsigned idle_cycles    = 0;
  int          burst_left     = 0;
  int unsigned clock_ms       = 0;
  int unsigned per_lo         = 300;
  int unsigned per_hi         = 1500;
  logic [31:0] tick           = '0;
  logic [7:0]  want_bpm;

  function automatic logic [7:0] predict_rate(input logic [SMP_BITS-1:0] smp,
                                              input logic [31:0] ts);
    int unsigned thr;
    int unsigned gap;
    int unsigned total;
    int unsigned mean;
    int unsigned bpm;
    avg_level = (avg_level * (AVG_WEIGHT - 1) + smp) / AVG_WEIGHT;
    thr = avg_level + thr_offset;
    if (smp > thr && !above) begin
      above = 1'b1;
      gap = ts - last_beat_ms;
      last_beat_ms = ts;
      if (!beat_seen) begin
        beat_seen = 1'b1;
        return 8'd0;
      end
      if (gap > gap_max || gap < gap_min) return 8'd0;
      gap_ring[ring_slot] = 16'(gap);
      ring_slot = (ring_slot + 1) % SLOTS;
      if (ring_fill < SLOTS) ring_fill++;
    end else if (smp <= thr) begin
      above = 1'b0;
    end
    if (ring_fill < SLOTS) return 8'd0;
    total = 0;
    foreach (gap_ring[k]) total += gap_ring[k];
    mean = total / SLOTS;
    if (mean == 0) return 8'd0;
    bpm = BPM_NUMERATOR / mean;
    if (bpm < bpm_min || bpm > bpm_max) return 8'd0;
    return 8'(bpm);
  endfunction

  function automatic void set_reg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      REG_THRESHOLD_OFFSET: thr_offset = val[9:0];
      REG_MIN_INTERVAL:     gap_min    = val;
      REG_MAX_INTERVAL:     gap_max    = val;
      REG_MIN_RATE:         bpm_min    = val[7:0];
      REG_MAX_RATE:         bpm_max    = val[7:0];
      default: ;
    endcase
  endfunction

  // upper bits above the register width are dropped by the block
  function automatic logic [15:0] with_junk(input int unsigned val,
                                            input int unsigned width);
    int unsigned junk;
    junk = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535) : 0;
    return 16'((junk << width) | val);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    set_reg(idx, val);
  endtask

  task automatic load_settings(input logic [15:0] offs, input logic [15:0] gmin,
                               input logic [15:0] gmax, input logic [15:0] rmin,
                               input logic [15:0] rmax);
    write_reg(REG_THRESHOLD_OFFSET, offs);
    write_reg(REG_MIN_INTERVAL, gmin);
    write_reg(REG_MAX_INTERVAL, gmax);
    write_reg(REG_MIN_RATE, rmin);
    write_reg(REG_MAX_RATE, rmax);
    write_reg(CFG_FIRST_SPARE + 3'($urandom_range(0, 2)), 16'($urandom()));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic feed_sample(input logic [SMP_BITS-1:0] smp, input logic [31:0] ts,
                             input bit fixed, input logic [7:0] fixed_bpm);
    logic [7:0] bpm;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 70)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_BITS'({ts, smp});
    do @(posedge clk); while (!s_tready);
    bpm = predict_rate(smp, ts);
    rate_queue.push_back(fixed ? fixed_bpm : bpm);
    samples_sent++;
  endtask

  task automatic wait_for_rates;
    s_tvalid <= 1'b0;
    while (rate_queue.size() != 0) @(posedge clk);
  endtask

  // low samples then one crossing per beat; messy trains add missed beats,
  // plateaus and wild intervals
  task automatic beat_train(input int unsigned beats, input int unsigned lo,
                            input int unsigned hi, input bit messy);
    int unsigned amp_lo;
    int unsigned amp;
    int unsigned base;
    int unsigned period;
    int unsigned lows;
    int unsigned stride;
    amp_lo = thr_offset + thr_offset / 6 + 24;
    if (amp_lo > 1023) amp_lo = 1023;
    amp  = $urandom_range(amp_lo, 1023);
    base = $urandom_range(0, 1023 - amp);
    repeat (beats) begin
      period = $urandom_range(lo, hi);
      if (messy && $urandom_range(0, 9) == 0) period = $urandom_range(0, 70000);
      lows   = $urandom_range(1, 6);
      stride = period / (lows + 1);
      repeat (lows) begin
        clock_ms += stride;
        feed_sample(SMP_BITS'(base + $urandom_range(0, 7)), clock_ms, 1'b0, 8'd0);
      end
      clock_ms += period - lows * stride;
      if (messy && $urandom_range(0, 15) == 0) begin
        feed_sample(SMP_BITS'(base), clock_ms, 1'b0, 8'd0);
      end else begin
        feed_sample(SMP_BITS'(base + amp), clock_ms, 1'b0, 8'd0);
        if (messy && $urandom_range(0, 5) == 0)
          feed_sample(SMP_BITS'(base + amp), clock_ms, 1'b0, 8'd0);
      end
    end
  endtask

  task automatic noise_burst(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 1) == 1) clock_ms = $urandom();
      else clock_ms += $urandom_range(0, 3000);
      feed_sample(SMP_BITS'($urandom_range(0, 1023)), clock_ms, 1'b0, 8'd0);
    end
  endtask

  task automatic random_settings;
    int unsigned offs;
    int unsigned gmin;
    int unsigned gmax;
    int unsigned rmin;
    int unsigned rmax;
    int unsigned pick;
    if ($urandom_range(0, 7) == 0) offs = ($urandom_range(0, 1) == 1) ? 1023 : 0;
    else offs = $urandom_range(0, 300);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      gmin = 1;
      gmax = 65535;
    end else if (pick == 1) begin
      gmin = $urandom_range(800, 2000);
      gmax = $urandom_range(1, 799);
    end else begin
      gmin = $urandom_range(200, 500);
      gmax = $urandom_range(900, 2500);
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      rmin = 0;
      rmax = 255;
    end else if (pick == 1) begin
      rmin = $urandom_range(100, 255);
      rmax = $urandom_range(0, 99);
    end else begin
      rmin = $urandom_range(0, 60);
      rmax = $urandom_range(100, 255);
    end
    load_settings(with_junk(offs, 10), 16'(gmin), 16'(gmax),
                  with_junk(rmin, 8), with_junk(rmax, 8));
    per_lo = (gmin > 250) ? gmin : 250;
    per_hi = (gmax < 2000) ? gmax : 2000;
    if (per_lo > per_hi) begin
      per_lo = 300;
      per_hi = 1500;
    end
    if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
  endtask

  // result side: stall pattern follows bits 9:8 of the tick counter
  always @(posedge clk) begin
    tick <= tick + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      case (tick[9:8])
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= 1'($urandom_range(0, 1));
        2'd2:    m_tready <= (tick[1:0] == 2'd0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      rates_checked++;
      if (m_tdata != 8'd0) rates_nonzero++;
      if (rate_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected rate beat %0d: got %0d", rates_checked, m_tdata);
      end else begin
        want_bpm = rate_queue.pop_front();
        if (m_tdata !== want_bpm) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("rate beat %0d: expected %0d, got %0d",
                     rates_checked, want_bpm, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no beat moved for %0d cycles, %0d rates outstanding",
               idle_cycles, rate_queue.size());
      $display("[pulse_rate_from_optical_samples_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    probe_t row;
    foreach (gap_ring[k]) gap_ring[k] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first beat, short and long intervals, ring fill at
    // 1000 ms (60 bpm) across the timestamp wrap, short interval once full
    probe_table.push_back('{10'd0,    TABLE_T0 + 0,    1'b1, 8'd0});
    probe_table.push_back('{10'd1023, TABLE_T0 + 1000, 1'b1, 8'd0});
    probe_table.push_back('{10'd1023, TABLE_T0 + 1100, 1'b1, 8'd0});
    probe_table.push_back('{10'd0,    TABLE_T0 + 1200, 1'b1, 8'd0});
    probe_table.push_back('{10'd1023, TABLE_T0 + 1250, 1'b1, 8'd0});
    probe_table.push_back('{10'd0,    TABLE_T0 + 1300, 1'b1, 8'd0});
    probe_table.push_back('{10'd1023, TABLE_T0 + 2900, 1'b1, 8'd0});
    for (int i = 0; i < SLOTS; i++) begin
      probe_table.push_back('{10'd0,    TABLE_T0 + 3400 + 1000 * i, 1'b1, 8'd0});
      probe_table.push_back('{10'd1023, TABLE_T0 + 3900 + 1000 * i, 1'b1,
                              (i == SLOTS - 1) ? 8'd60 : 8'd0});
    end
    probe_table.push_back('{10'd0,    TABLE_T0 + 11000, 1'b1, 8'd60});
    probe_table.push_back('{10'd1023, TABLE_T0 + 11200, 1'b1, 8'd0});
    foreach (probe_table[i]) begin
      row = probe_table[i];
      feed_sample(row.smp, row.ts, row.fixed, row.bpm);
    end
    clock_ms = TABLE_T0 + 12000;
    wait_for_rates();

    // zero intervals fill the ring: mean of zero
    load_settings(16'd10, 16'd0, 16'd1500, 16'd40, 16'd180);
    beat_train(12, 0, 0, 1'b0);
    wait_for_rates();
    // crossed interval bounds
    load_settings(16'd10, 16'd1000, 16'd500, 16'd40, 16'd180);
    beat_train(10, 700, 700, 1'b0);
    wait_for_rates();
    // crossed rate limits
    load_settings(16'd10, 16'd330, 16'd1500, 16'd200, 16'd100);
    beat_train(12, 330, 1500, 1'b0);
    wait_for_rates();
    // everything at the top, written with oversized words
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    beat_train(6, 65535, 65535, 1'b0);
    noise_burst(6);
    wait_for_rates();
    // widest window: zero rate from the longest interval, 255 bpm at 235 ms
    load_settings(16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd255);
    beat_train(10, 65535, 65535, 1'b0);
    beat_train(10, 235, 235, 1'b0);
    wait_for_rates();
    // narrowest window
    load_settings(16'd0, 16'd1, 16'd1, 16'd0, 16'd0);
    beat_train(10, 1, 1, 1'b0);
    wait_for_rates();

    while (samples_sent < TABLE_ROWS + RANDOM_SAMPLES) begin
      random_settings();
      beat_train($urandom_range(6, 30), per_lo, per_hi, 1'b1);
      if ($urandom_range(0, 2) == 0) noise_burst($urandom_range(1, 12));
      if ($urandom_range(0, 1) == 1) beat_train($urandom_range(4, 16), per_lo, per_hi, 1'b1);
      wait_for_rates();
    end

    repeat (80) @(posedge clk);
    $display("%0d samples under %0d register settings, %0d rates checked",
             samples_sent, settings_used, rates_checked);
    $display("%0d rates non-zero, %0d failures", rates_nonzero, fail_count);
    if (fail_count == 0 && rate_queue.size() == 0) begin
      $display("[pulse_rate_from_optical_samples_top] OK");
    end else begin
      $display("[pulse_rate_from_optical_samples_top] ERROR");
    end
    $finish;
  end

endmodule
